// ===== rtl/cmdf_pkg.sv =====
package cmdf_pkg;

  // sample and result field widths
  localparam int SAMPLE_W = 10;
  localparam int COUNT_W  = 7;

  // default sizing
  localparam int DEF_MAX_WINDOW        = 64;
  localparam int DEF_MAX_CLUSTER_SLOTS = 8;

  // register reset values
  localparam logic [6:0] RST_WINDOW_LENGTH     = 7'd35;
  localparam logic [7:0] RST_JOIN_TOLERANCE    = 8'd5;
  localparam logic [3:0] RST_MAX_CLUSTERS      = 4'd5;
  localparam logic [6:0] RST_AMBIGUITY_PERCENT = 7'd20;

  // register indexes
  localparam logic [1:0] REG_WINDOW_LENGTH     = 2'd0;
  localparam logic [1:0] REG_JOIN_TOLERANCE    = 2'd1;
  localparam logic [1:0] REG_MAX_CLUSTERS      = 2'd2;
  localparam logic [1:0] REG_AMBIGUITY_PERCENT = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_AMBIG    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_WALK_INIT,
    S_WALK_RD,
    S_WALK_PROC,
    S_CLOSE,
    S_SCAN,
    S_DECIDE,
    S_DIV,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic ins_shift;
    logic ins_put;
    logic walk_init;
    logic walk_read;
    logic walk_proc;
    logic close_last;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic j_zero;
    logic rd_gt_v;
    logic full;
    logic walk_last;
    logic reject;
    logic scan_last;
    logic amb;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/cmdf_ctrl.sv =====
module cmdf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cmdf_pkg::stat_t stat,
  output cmdf_pkg::cmd_t  cmd,
  output logic           busy
);
  import cmdf_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_INS_RD;
      end
      S_INS_RD: begin
        if (stat.j_zero) state_next = stat.full ? S_WALK_INIT : S_IDLE;
        else state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (stat.rd_gt_v) state_next = S_INS_RD;
        else state_next = stat.full ? S_WALK_INIT : S_IDLE;
      end
      S_WALK_INIT: state_next = S_WALK_RD;
      S_WALK_RD:   state_next = S_WALK_PROC;
      S_WALK_PROC: begin
        state_next = stat.walk_last ? S_CLOSE : S_WALK_RD;
      end
      S_CLOSE: state_next = S_SCAN;
      S_SCAN: begin
        if (stat.reject) state_next = S_EMIT;
        else if (stat.scan_last) state_next = S_DECIDE;
      end
      S_DECIDE: state_next = stat.amb ? S_EMIT : S_DIV;
      S_DIV: begin
        if (stat.div_done) state_next = S_EMIT;
      end
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_INS_RD:    cmd.ins_put = stat.j_zero;
      S_INS_CMP: begin
        cmd.ins_shift = stat.rd_gt_v;
        cmd.ins_put   = !stat.rd_gt_v;
      end
      S_WALK_INIT: cmd.walk_init = 1'b1;
      S_WALK_RD:   cmd.walk_read = 1'b1;
      S_WALK_PROC: cmd.walk_proc = 1'b1;
      S_CLOSE:     cmd.close_last = 1'b1;
      S_SCAN:      cmd.scan_step = !stat.reject;
      S_DECIDE:    cmd.div_start = !stat.amb;
      S_DIV:       cmd.div_step = 1'b1;
      S_EMIT:      cmd.emit = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

// ===== rtl/cmdf_datapath.sv =====
module cmdf_datapath #(
  parameter int MAX_WINDOW        = cmdf_pkg::DEF_MAX_WINDOW,
  parameter int MAX_CLUSTER_SLOTS = cmdf_pkg::DEF_MAX_CLUSTER_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cmdf_pkg::SAMPLE_W-1:0] sample_cm,
  input  logic [6:0]                    window_length,
  input  logic [7:0]                    join_tolerance,
  input  logic [3:0]                    max_clusters,
  input  logic [6:0]                    ambiguity_percent,
  input  cmdf_pkg::cmd_t                cmd,
  output cmdf_pkg::stat_t               stat,
  output logic                          done,
  output logic                          found,
  output logic [cmdf_pkg::SAMPLE_W-1:0] distance_cm,
  output logic [1:0]                    status,
  output logic [cmdf_pkg::COUNT_W-1:0]  cluster_count,
  output logic [cmdf_pkg::COUNT_W-1:0]  winner_size
);
  import cmdf_pkg::*;

  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int SUMW = SAMPLE_W + CW;
  localparam int SW   = (MAX_CLUSTER_SLOTS > 1) ? $clog2(MAX_CLUSTER_SLOTS) : 1;
  localparam int CMPW = (CW > 7) ? CW : 7;
  localparam int PW   = SAMPLE_W + 1 + CW;
  localparam int MW   = CW + 7;
  localparam int DCW  = $clog2(SUMW);

  // sample memory and insertion sort state
  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]       mem_ra;
  logic [SAMPLE_W-1:0] v;
  logic [AW-1:0]       j;
  logic [AW-1:0]       fill;
  logic [CW-1:0]       n;
  logic                full;
  logic [CW-1:0]       n_new;
  logic                full_new;

  // cluster walk state
  logic [AW-1:0]   wi;
  logic [SUMW-1:0] cur_sum;
  logic [CW-1:0]   cur_size;
  logic [CW-1:0]   nclu;
  logic [CW-1:0]   best;
  logic [SUMW-1:0] csum  [MAX_CLUSTER_SLOTS];
  logic [CW-1:0]   csize [MAX_CLUSTER_SLOTS];
  logic [CW-1:0]   close_idx;
  logic            join_ok;
  logic            do_close;
  logic [SAMPLE_W:0] k;
  logic [PW-1:0]   prod;

  // rival scan and divider state
  logic [SW-1:0]   si;
  logic            have_w;
  logic            amb;
  logic [SUMW-1:0] win_sum;
  logic [CW-1:0]   win_size;
  logic [CW-1:0]   c;
  logic [MW-1:0]   gap_lhs;
  logic [MW-1:0]   gap_rhs;
  logic [SUMW-1:0] dq;
  logic [CW-1:0]   drem;
  logic [DCW-1:0]  dcnt;
  logic [CW:0]     dtmp;
  logic            dge;
  logic            reject;
  logic            ok;

  // window fill bookkeeping
  assign n_new    = CW'(fill) + CW'(1);
  assign full_new = (CMPW'(n_new) >= CMPW'(2)) &&
                    ((CMPW'(n_new) >= CMPW'(window_length)) ||
                     (n_new >= CW'(MAX_WINDOW)));

  // memory port
  assign mem_ra = cmd.walk_read ? wi : AW'(j - AW'(1));

  always_ff @(posedge clk) begin
    if (cmd.ins_shift) mem[j] <= rd_data;
    else if (cmd.ins_put) mem[j] <= v;
    rd_data <= mem[mem_ra];
  end

  // incoming sample and insertion pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.load) begin
      fill <= full_new ? '0 : AW'(n_new);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v    <= sample_cm;
      j    <= fill;
      n    <= n_new;
      full <= full_new;
    end else if (cmd.ins_shift) begin
      j <= AW'(j - AW'(1));
    end
  end

  // join test without a divide: mean > s - tol  <=>  sum >= (s - tol + 1) * size
  assign k       = (SAMPLE_W + 1)'(rd_data) - (SAMPLE_W + 1)'(join_tolerance)
                   + (SAMPLE_W + 1)'(1);
  assign prod    = PW'(k) * PW'(cur_size);
  assign join_ok = (nclu != '0) &&
                   ((rd_data < SAMPLE_W'(join_tolerance)) || (PW'(cur_sum) >= prod));
  assign do_close  = (cmd.walk_proc && !join_ok && (nclu != '0)) || cmd.close_last;
  assign close_idx = CW'(nclu - CW'(1));

  // cluster walk
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      wi       <= '0;
      nclu     <= '0;
      best     <= '0;
      cur_sum  <= '0;
      cur_size <= '0;
    end else if (cmd.walk_proc) begin
      wi <= AW'(wi + AW'(1));
      if (join_ok) begin
        cur_sum  <= SUMW'(cur_sum + SUMW'(rd_data));
        cur_size <= CW'(cur_size + CW'(1));
      end else begin
        nclu     <= CW'(nclu + CW'(1));
        cur_sum  <= SUMW'(rd_data);
        cur_size <= CW'(1);
      end
    end
    if (do_close) begin
      if (close_idx < CW'(MAX_CLUSTER_SLOTS)) begin
        csum[SW'(close_idx)]  <= cur_sum;
        csize[SW'(close_idx)] <= cur_size;
      end
      if (cur_size > best) best <= cur_size;
    end
  end

  // rival scan: first largest cluster wins, any close rival is ambiguous
  assign c       = csize[si];
  assign gap_lhs = MW'(best - c) * MW'(7'd100);
  assign gap_rhs = MW'(ambiguity_percent) * MW'(best);

  always_ff @(posedge clk) begin
    if (cmd.close_last) begin
      si     <= '0;
      have_w <= 1'b0;
      amb    <= 1'b0;
    end else if (cmd.scan_step) begin
      si <= SW'(si + SW'(1));
      if ((c == best) && !have_w) begin
        have_w   <= 1'b1;
        win_sum  <= csum[si];
        win_size <= c;
      end else if ((c == best) || (gap_lhs < gap_rhs)) begin
        amb <= 1'b1;
      end
    end
  end

  // restoring divider for the winning mean, one quotient bit a cycle
  assign dtmp = {drem, dq[SUMW-1]};
  assign dge  = dtmp >= (CW + 1)'(win_size);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq   <= win_sum;
      drem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      drem <= dge ? CW'(dtmp - (CW + 1)'(win_size)) : CW'(dtmp);
      dq   <= {dq[SUMW-2:0], dge};
      dcnt <= DCW'(dcnt + DCW'(1));
    end
  end

  assign reject = (nclu > CW'(max_clusters)) || (CMPW'(nclu) > CMPW'(max_clusters)) ||
                  (nclu > CW'(MAX_CLUSTER_SLOTS));
  assign ok     = !reject && !amb;

  // status to controller
  always_comb begin
    stat           = '0;
    stat.j_zero    = (j == '0);
    stat.rd_gt_v   = (rd_data > v);
    stat.full      = full;
    stat.walk_last = (wi == AW'(n - CW'(1)));
    stat.reject    = reject;
    stat.scan_last = (CW'(si) == CW'(nclu - CW'(1)));
    stat.amb       = amb;
    stat.div_done  = (dcnt == DCW'(SUMW - 1));
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found         <= ok;
      distance_cm   <= ok ? dq[SAMPLE_W-1:0] : '0;
      status        <= reject ? ST_TOO_MANY : (amb ? ST_AMBIG : ST_OK);
      cluster_count <= COUNT_W'(nclu);
      winner_size   <= COUNT_W'(best);
    end
  end

endmodule

// ===== rtl/cluster_mode_distance_filter_core.sv =====
// channel   | handshake            | payload
// ----------+----------------------+-----------------------------------------------
// sample    | start, busy          | sample_cm
// result    | done (one cycle)     | found, distance_cm, status, cluster_count,
//           |                      | winner_size
// config    | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// a sample is insertion sorted into the sample ram (one read and one write port): each
// stored sample above it is read, compared and moved up a slot. the sample that fills
// the window then drives the cluster walk over the window samples, closes the last
// cluster, scans the clusters (stopping at once if too many), decides, runs the mean
// divider unless ambiguous, and emits. busy stays high until the sample is through.
// synchronous active-high reset clears the fsm, fill count, done and config registers.
// the receiver cannot stall: each result beat is on the ports for one cycle.
module cluster_mode_distance_filter_core #(
  parameter int MAX_WINDOW        = cmdf_pkg::DEF_MAX_WINDOW,
  parameter int MAX_CLUSTER_SLOTS = cmdf_pkg::DEF_MAX_CLUSTER_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [cmdf_pkg::SAMPLE_W-1:0] sample_cm,
  output logic                          done,
  output logic                          found,
  output logic [cmdf_pkg::SAMPLE_W-1:0] distance_cm,
  output logic [1:0]                    status,
  output logic [cmdf_pkg::COUNT_W-1:0]  cluster_count,
  output logic [cmdf_pkg::COUNT_W-1:0]  winner_size,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [7:0]                    cfg_data
);
  import cmdf_pkg::*;

  logic [6:0] window_length;
  logic [7:0] join_tolerance;
  logic [3:0] max_clusters;
  logic [6:0] ambiguity_percent;
  cmd_t       cmd;
  stat_t      stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= RST_WINDOW_LENGTH;
      join_tolerance    <= RST_JOIN_TOLERANCE;
      max_clusters      <= RST_MAX_CLUSTERS;
      ambiguity_percent <= RST_AMBIGUITY_PERCENT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:     window_length     <= cfg_data[6:0];
        REG_JOIN_TOLERANCE:    join_tolerance    <= cfg_data;
        REG_MAX_CLUSTERS:      max_clusters      <= cfg_data[3:0];
        REG_AMBIGUITY_PERCENT: ambiguity_percent <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  cmdf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cmdf_datapath #(
    .MAX_WINDOW        (MAX_WINDOW),
    .MAX_CLUSTER_SLOTS (MAX_CLUSTER_SLOTS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .sample_cm         (sample_cm),
    .window_length     (window_length),
    .join_tolerance    (join_tolerance),
    .max_clusters      (max_clusters),
    .ambiguity_percent (ambiguity_percent),
    .cmd               (cmd),
    .stat              (stat),
    .done              (done),
    .found             (found),
    .distance_cm       (distance_cm),
    .status            (status),
    .cluster_count     (cluster_count),
    .winner_size       (winner_size)
  );

endmodule
